### rtl/tcws_pkg.sv
// Shared constants and types of the text console core.
// No dependencies; every other file uses it by scoped names.
package tcws_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 16;
    localparam int SIZE    = COLUMNS * ROWS + ROWS - 1;

    // Fixed field widths of the request and result channels.
    localparam int CMD_W  = 1;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int LEN_W  = 11;
    localparam int FILL_W = 7;

    // Internal widths derived from the geometry.
    localparam int POS_W  = $clog2(SIZE);
    localparam int SUM_W  = POS_W + 1;
    localparam int HEAD_W = $clog2(ROWS);
    localparam int CNT_W  = $clog2(ROWS + 1);

    // Request queue between front and back end.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CMD_W-1:0]  CMD_APPEND = 1'b0;
    localparam logic [CMD_W-1:0]  CMD_READ   = 1'b1;
    localparam logic [CHAR_W-1:0] NEWLINE    = 8'h0A;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic              wrap;   // a newline goes in before ch
        logic [FILL_W-1:0] fill;   // line fill after this request
    } entry_t;

endpackage

### rtl/tcws_ifs.sv
// Valid/ready channel interfaces of the text console core.
// Depends on tcws_pkg for field widths.
interface tcws_in_if;
    logic                        valid;
    logic                        ready;
    logic [tcws_pkg::CMD_W-1:0]  cmd;
    logic [tcws_pkg::CHAR_W-1:0] char_in;
    logic [tcws_pkg::IDX_W-1:0]  read_index;

    modport source (output valid, cmd, char_in, read_index, input ready);
    modport sink   (input valid, cmd, char_in, read_index, output ready);
endinterface

interface tcws_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcws_pkg::CHAR_W-1:0] read_char;
    logic [tcws_pkg::LEN_W-1:0]  view_length;
    logic [tcws_pkg::FILL_W-1:0] line_fill;
    logic [tcws_pkg::IDX_W-1:0]  view_start;

    modport source (output valid, read_char, view_length, line_fill, view_start,
                    input ready);
    modport sink   (input valid, read_char, view_length, line_fill, view_start,
                    output ready);
endinterface

### rtl/tcws_front.sv
// Front end: accepts requests, tracks the line fill, flags wraps.
// Depends on tcws_pkg and tcws_in_if.
module tcws_front (
    input  logic              clk,
    input  logic              rst_n,
    tcws_in_if.sink           request,
    input  logic              q_ready,
    output logic              q_push,
    output tcws_pkg::entry_t  q_entry
);

    logic [tcws_pkg::FILL_W-1:0] fill_reg;
    logic [tcws_pkg::FILL_W-1:0] fill_next;
    logic                        line_full;
    logic                        is_nl;
    logic                        wrap;

    assign request.ready = q_ready;
    assign q_push        = request.valid && q_ready;

    assign line_full = fill_reg >= tcws_pkg::FILL_W'(tcws_pkg::COLUMNS);
    assign is_nl     = request.char_in == tcws_pkg::NEWLINE;
    assign wrap      = (request.cmd == tcws_pkg::CMD_APPEND) && line_full && !is_nl;

    always_comb
    begin
        fill_next = fill_reg;
        if (request.cmd == tcws_pkg::CMD_APPEND)
        begin
            priority if (is_nl)
                fill_next = '0;
            else if (wrap)
                fill_next = tcws_pkg::FILL_W'(1);
            else if (!line_full)
                fill_next = fill_reg + 1'b1;
        end
    end

    always_comb
    begin
        q_entry.cmd  = request.cmd;
        q_entry.ch   = request.char_in;
        q_entry.idx  = request.read_index;
        q_entry.wrap = wrap;
        q_entry.fill = fill_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (q_push)
            fill_reg <= fill_next;
    end

endmodule

### rtl/tcws_queue.sv
// Short request queue that decouples the front and back ends.
// Depends on tcws_pkg.
module tcws_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcws_pkg::entry_t  push_entry,
    output logic              push_ready,
    output logic              head_valid,
    output tcws_pkg::entry_t  head_entry,
    input  logic              pop
);

    tcws_pkg::entry_t              slots_reg [tcws_pkg::QDEPTH];
    logic [tcws_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tcws_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tcws_pkg::QCNT_W-1:0]   count_reg;
    logic [tcws_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = count_reg != tcws_pkg::QCNT_W'(tcws_pkg::QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = slots_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        count_next = count_reg + tcws_pkg::QCNT_W'(do_push)
                               - tcws_pkg::QCNT_W'(do_pop);
    end

    function automatic logic [tcws_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tcws_pkg::QPTR_W-1:0] p);
        return (p == tcws_pkg::QPTR_W'(tcws_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### rtl/tcws_back.sv
// Back end: character ring, newline list, window bookkeeping, result stage.
// Depends on tcws_pkg and tcws_out_if.
module tcws_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  tcws_pkg::entry_t  q_entry,
    output logic              q_pop,
    tcws_out_if.source        result
);

    localparam logic PH_FIRST  = 1'b0;
    localparam logic PH_SECOND = 1'b1;

    // Character ring; bytes never written read as newline.
    logic [tcws_pkg::CHAR_W-1:0] mem [tcws_pkg::SIZE];
    logic [tcws_pkg::CHAR_W-1:0] rdata_reg;

    logic                        phase_reg;
    logic                        phase_next;
    logic [tcws_pkg::POS_W-1:0]  wp_reg;
    logic [tcws_pkg::POS_W-1:0]  wp_next;
    logic [tcws_pkg::LEN_W-1:0]  len_reg;
    logic [tcws_pkg::LEN_W-1:0]  len_next;
    logic [tcws_pkg::POS_W-1:0]  start_reg;
    logic [tcws_pkg::POS_W-1:0]  start_next;
    logic                        wrapped_reg;
    logic [tcws_pkg::POS_W-1:0]  nl_pos_reg [tcws_pkg::ROWS];
    logic [tcws_pkg::HEAD_W-1:0] nl_head_reg;
    logic [tcws_pkg::HEAD_W-1:0] nl_head_next;
    logic [tcws_pkg::CNT_W-1:0]  nl_cnt_reg;
    logic [tcws_pkg::CNT_W-1:0]  nl_cnt_next;

    // Result stage
    logic                        r_valid_reg;
    logic                        r_read_reg;
    logic                        r_blank_reg;
    logic [tcws_pkg::LEN_W-1:0]  r_len_reg;
    logic [tcws_pkg::FILL_W-1:0] r_fill_reg;
    logic [tcws_pkg::POS_W-1:0]  r_start_reg;

    logic                        advance;
    logic                        is_append;
    logic                        do_nl;
    logic                        do_char;
    logic                        do_read;
    logic                        put;
    logic [tcws_pkg::CHAR_W-1:0] put_b;
    logic                        put_is_nl;
    logic [tcws_pkg::POS_W-1:0]  head_val;
    logic                        full;
    logic                        pop_old;
    logic                        pop_limit;
    logic [tcws_pkg::HEAD_W-1:0] head_inc;
    logic [tcws_pkg::CNT_W:0]    tail_sum;
    logic [tcws_pkg::HEAD_W-1:0] tail;
    logic [tcws_pkg::SUM_W-1:0]  addr_sum;
    logic [tcws_pkg::POS_W-1:0]  rd_addr;
    logic                        in_range;
    logic                        written;

    assign advance   = !r_valid_reg || result.ready;
    assign is_append = q_entry.cmd == tcws_pkg::CMD_APPEND;
    // inserted newline needs no result slot
    assign do_nl     = q_valid && is_append && q_entry.wrap && (phase_reg == PH_FIRST);
    assign do_char   = q_valid && is_append && (!q_entry.wrap || (phase_reg == PH_SECOND))
                       && advance;
    assign do_read   = q_valid && !is_append && advance;
    assign q_pop     = do_char || do_read;
    assign put       = do_nl || do_char;
    assign put_b     = do_nl ? tcws_pkg::NEWLINE : q_entry.ch;
    assign put_is_nl = put_b == tcws_pkg::NEWLINE;

    always_comb
    begin
        phase_next = phase_reg;
        if (do_nl)
            phase_next = PH_SECOND;
        else if (do_char)
            phase_next = PH_FIRST;
    end

    // One byte into the ring: window, newline list and start update.
    assign head_val  = nl_pos_reg[nl_head_reg];
    assign full      = len_reg == tcws_pkg::LEN_W'(tcws_pkg::SIZE);
    // oldest byte overwritten while it is the oldest listed newline
    assign pop_old   = full && (nl_cnt_reg != '0) && (head_val == wp_reg);
    // a new newline would make ROWS of them: window moves past the oldest
    assign pop_limit = put_is_nl && !pop_old
                       && (nl_cnt_reg == tcws_pkg::CNT_W'(tcws_pkg::ROWS - 1));
    assign head_inc  = (nl_head_reg == tcws_pkg::HEAD_W'(tcws_pkg::ROWS - 1))
                       ? '0 : nl_head_reg + 1'b1;
    // tail slot is the same whether or not pop_old fired
    assign tail_sum  = (tcws_pkg::CNT_W + 1)'(nl_head_reg) + (tcws_pkg::CNT_W + 1)'(nl_cnt_reg);
    assign tail      = (tail_sum >= (tcws_pkg::CNT_W + 1)'(tcws_pkg::ROWS))
                       ? tcws_pkg::HEAD_W'(tail_sum - (tcws_pkg::CNT_W + 1)'(tcws_pkg::ROWS))
                       : tcws_pkg::HEAD_W'(tail_sum);

    always_comb
    begin
        wp_next = (wp_reg == tcws_pkg::POS_W'(tcws_pkg::SIZE - 1)) ? '0 : wp_reg + 1'b1;
        nl_head_next = (pop_old || pop_limit) ? head_inc : nl_head_reg;
        nl_cnt_next  = nl_cnt_reg + tcws_pkg::CNT_W'(put_is_nl)
                                  - tcws_pkg::CNT_W'(pop_old)
                                  - tcws_pkg::CNT_W'(pop_limit);
        priority if (pop_limit)
        begin
            start_next = (head_val == tcws_pkg::POS_W'(tcws_pkg::SIZE - 1))
                         ? '0 : head_val + 1'b1;
            len_next   = (wp_reg >= head_val)
                         ? tcws_pkg::LEN_W'(wp_reg - head_val)
                         : tcws_pkg::LEN_W'(tcws_pkg::SUM_W'(wp_reg)
                                            + tcws_pkg::SUM_W'(tcws_pkg::SIZE)
                                            - tcws_pkg::SUM_W'(head_val));
        end
        else if (!full)
        begin
            start_next = start_reg;
            len_next   = len_reg + 1'b1;
        end
        else
        begin
            start_next = wp_next;
            len_next   = len_reg;
        end
    end

    // Read address inside the window
    assign in_range = q_entry.idx < len_reg;
    assign addr_sum = tcws_pkg::SUM_W'(start_reg) + tcws_pkg::SUM_W'(q_entry.idx);
    assign rd_addr  = (addr_sum >= tcws_pkg::SUM_W'(tcws_pkg::SIZE))
                      ? tcws_pkg::POS_W'(addr_sum - tcws_pkg::SUM_W'(tcws_pkg::SIZE))
                      : tcws_pkg::POS_W'(addr_sum);
    assign written  = wrapped_reg || (rd_addr < wp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            wp_reg      <= '0;
            len_reg     <= tcws_pkg::LEN_W'(tcws_pkg::ROWS - 1);
            start_reg   <= tcws_pkg::POS_W'(tcws_pkg::SIZE - (tcws_pkg::ROWS - 1));
            wrapped_reg <= 1'b0;
            nl_head_reg <= '0;
            nl_cnt_reg  <= tcws_pkg::CNT_W'(tcws_pkg::ROWS - 1);
            for (int i = 0; i < tcws_pkg::ROWS; i++)
            begin
                nl_pos_reg[i] <= (i < tcws_pkg::ROWS - 1)
                    ? tcws_pkg::POS_W'(tcws_pkg::SIZE - (tcws_pkg::ROWS - 1) + i)
                    : '0;
            end
            r_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (put)
            begin
                wp_reg      <= wp_next;
                len_reg     <= len_next;
                start_reg   <= start_next;
                nl_head_reg <= nl_head_next;
                nl_cnt_reg  <= nl_cnt_next;
                if (wp_reg == tcws_pkg::POS_W'(tcws_pkg::SIZE - 1))
                    wrapped_reg <= 1'b1;
                if (put_is_nl)
                    nl_pos_reg[tail] <= wp_reg;
            end
            if (advance)
                r_valid_reg <= do_char || do_read;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (do_char)
        begin
            r_read_reg  <= 1'b0;
            r_blank_reg <= 1'b0;
            r_len_reg   <= len_next;
            r_start_reg <= start_next;
            r_fill_reg  <= q_entry.fill;
        end
        else if (do_read)
        begin
            r_read_reg  <= in_range && written;
            r_blank_reg <= in_range && !written;
            r_len_reg   <= len_reg;
            r_start_reg <= start_reg;
            r_fill_reg  <= q_entry.fill;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
            mem[wp_reg] <= put_b;
        if (do_read)
            rdata_reg <= mem[rd_addr];
    end

    assign result.valid       = r_valid_reg;
    assign result.read_char   = r_read_reg ? rdata_reg
                              : (r_blank_reg ? tcws_pkg::NEWLINE : '0);
    assign result.view_length = r_len_reg;
    assign result.line_fill   = r_fill_reg;
    assign result.view_start  = tcws_pkg::IDX_W'(r_start_reg);

`ifndef SYNTHESIS
    a_nl_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nl_cnt_reg <= tcws_pkg::CNT_W'(tcws_pkg::ROWS - 1))
        else $error("newline count reached ROWS at rest");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= tcws_pkg::LEN_W'(tcws_pkg::SIZE))
        else $error("window longer than ring");

    a_second_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SECOND) |-> (q_valid && is_append && q_entry.wrap))
        else $error("second phase without a wrapping append at queue head");

    // a stalled ring read keeps rdata_reg steady at the output
    a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid_reg && r_read_reg && !result.ready) |=> $stable(rdata_reg))
        else $error("read data changed under a stalled result");

    a_limit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        put |-> !(pop_old && pop_limit))
        else $error("both newline pops in one write");
`endif

endmodule

### rtl/text_console_wrap_scroll_core.sv
// Top level of the text console core: front end, request queue, back end.
// Depends on tcws_pkg, tcws_ifs, tcws_front, tcws_queue and tcws_back.
//
// Text console with scrollback and line wrap over a ring of
// COLUMNS*ROWS+ROWS-1 character bytes (1295 at 80x16). A request either
// appends one character (cmd 0) or reads the visible window at read_index
// (cmd 1); every request returns exactly one result carrying read_char
// (0 for appends and for reads past the window), view_length, line_fill and
// view_start. A non-newline character arriving on a full line of COLUMNS
// characters gets a newline inserted before it. The window spans at most
// ROWS lines. Throughput: one request per cycle while the result output is
// not stalled; an append that wraps holds the back end longer because both
// bytes go through the single ring write port. The queue takes a request
// at acceptance; the back end then executes it from the queue head, reads
// the ring and loads the result register that offers the result, a
// wrapping append writing its inserted newline first. The ring needs no
// clearing pass after reset: positions not yet written since reset read as
// newline, tracked by the write pointer and a wrapped flag, so requests are
// taken right out of reset.
module text_console_wrap_scroll_core (
    input  logic        clk,
    input  logic        rst_n,
    tcws_in_if.sink     request,
    tcws_out_if.source  result
);

    logic              push;
    logic              push_ready;
    tcws_pkg::entry_t  push_entry;
    logic              head_valid;
    tcws_pkg::entry_t  head_entry;
    logic              pop;

    // Front end tracks the line fill and decides on wraps at acceptance.
    tcws_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .q_ready (push_ready),
        .q_push  (push),
        .q_entry (push_entry)
    );

    // Two-entry queue lets the front keep accepting while the back stalls.
    tcws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    // Back end owns the ring, the newline list and the result register.
    tcws_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (head_valid),
        .q_entry (head_entry),
        .q_pop   (pop),
        .result  (result)
    );

endmodule

### test/testbench.sv
// Self-checking bench for the text console core: random and directed requests.
// Depends on tcws_pkg, tcws_ifs and text_console_wrap_scroll_core from rtl.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog: cycles with no request or result moving before we give up.
    // Worst honest idle is the receiver hold-off plus the pipeline.
    localparam int IDLE_LIMIT  = 5000;
    localparam int RANDOM_REQS = 1700;
    localparam int TAIL_CYCLES = 20;

    // One request as the stimulus generator queues it. drain makes the
    // sender hold this request until every outstanding result came back.
    typedef struct {
        logic [tcws_pkg::CMD_W-1:0]  cmd;
        logic [tcws_pkg::CHAR_W-1:0] ch;
        logic [tcws_pkg::IDX_W-1:0]  idx;
        bit                          drain;
    } console_req_t;

    typedef struct packed {
        logic [tcws_pkg::CHAR_W-1:0] read_char;
        logic [tcws_pkg::LEN_W-1:0]  view_length;
        logic [tcws_pkg::FILL_W-1:0] line_fill;
        logic [tcws_pkg::IDX_W-1:0]  view_start;
    } view_t;

    logic clk;
    logic rst_n;

    tcws_in_if  req_ch ();
    tcws_out_if res_ch ();

    text_console_wrap_scroll_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    //------------------------------------------------------------------
    // Console shadow: our own copy of the ring, tail, window and the list
    // of newline positions inside the window (oldest first, circular).
    //------------------------------------------------------------------
    logic [tcws_pkg::CHAR_W-1:0] ring [tcws_pkg::SIZE];
    int unsigned tail_pos;
    int unsigned win_len;
    int unsigned fill;
    int unsigned nl_list [tcws_pkg::ROWS];
    int unsigned nl_first;
    int unsigned nl_total;

    // Stats for the closing summary.
    int unsigned n_wraps;
    int unsigned n_reads_in;
    int unsigned n_reads_past;
    int unsigned n_full_ring;

    function automatic void nl_drop();
        if (nl_total > 0)
        begin
            nl_first = (nl_first + 1) % tcws_pkg::ROWS;
            nl_total--;
        end
    endfunction

    // Append one byte at the tail, evicting the oldest byte once the ring
    // is full, and trimming the window to ROWS lines.
    function automatic void put_char(logic [tcws_pkg::CHAR_W-1:0] b);
        int unsigned wp;
        int unsigned head_pos;
        wp = tail_pos % tcws_pkg::SIZE;
        if (win_len < tcws_pkg::SIZE)
            win_len++;
        else if (nl_total > 0 && nl_list[nl_first] == wp)
            nl_drop();    // an evicted newline leaves the list too
        ring[wp] = b;
        if (b == tcws_pkg::NEWLINE)
        begin
            if (nl_total >= tcws_pkg::ROWS)
                nl_drop();
            nl_list[(nl_first + nl_total) % tcws_pkg::ROWS] = wp;
            nl_total++;
        end
        tail_pos = (wp + 1) % tcws_pkg::SIZE;
        // A ROWS-th newline pushes the window start past the oldest one.
        if (nl_total >= tcws_pkg::ROWS)
        begin
            head_pos = (nl_list[nl_first] + 1) % tcws_pkg::SIZE;
            nl_drop();
            win_len = (tail_pos + tcws_pkg::SIZE - head_pos) % tcws_pkg::SIZE;
        end
    endfunction

    // Apply one accepted request to the shadow and return the view the
    // block must report for it.
    function automatic view_t console_apply(console_req_t r);
        view_t       v;
        int unsigned start;
        int unsigned rd;
        if (r.cmd == tcws_pkg::CMD_APPEND)
        begin
            if (fill >= tcws_pkg::COLUMNS && r.ch != tcws_pkg::NEWLINE)
            begin
                put_char(tcws_pkg::NEWLINE);    // line full: wrap first
                fill = 0;
                n_wraps++;
            end
            put_char(r.ch);
            if (r.ch == tcws_pkg::NEWLINE)
                fill = 0;
            else if (fill < tcws_pkg::COLUMNS)
                fill++;
            if (win_len == tcws_pkg::SIZE)
                n_full_ring++;
        end
        start = (tail_pos + tcws_pkg::SIZE - (win_len % (tcws_pkg::SIZE + 1)))
                % tcws_pkg::SIZE;
        rd = 0;
        if (r.cmd == tcws_pkg::CMD_READ)
        begin
            if (r.idx < win_len)
            begin
                rd = ring[(start + r.idx) % tcws_pkg::SIZE];
                n_reads_in++;
            end
            else
                n_reads_past++;
        end
        v.read_char   = rd[tcws_pkg::CHAR_W-1:0];
        v.view_length = win_len[tcws_pkg::LEN_W-1:0];
        v.line_fill   = fill[tcws_pkg::FILL_W-1:0];
        v.view_start  = start[tcws_pkg::IDX_W-1:0];
        return v;
    endfunction

    //------------------------------------------------------------------
    // Queues shared by generator, driver and monitor.
    //------------------------------------------------------------------
    console_req_t req_pending [$];    // generated, not yet offered
    view_t        pending_views [$];  // predicted, result not yet seen
    console_req_t cur;                // request currently on the bus
    int unsigned  n_generated;
    int unsigned  n_accepted;
    int unsigned  n_results;
    int unsigned  n_errors;

    task automatic push_req(logic [tcws_pkg::CMD_W-1:0] cmd,
                            logic [tcws_pkg::CHAR_W-1:0] ch,
                            logic [tcws_pkg::IDX_W-1:0] idx, bit drain);
        console_req_t r;
        r.cmd   = cmd;
        r.ch    = ch;
        r.idx   = idx;
        r.drain = drain;
        req_pending.push_back(r);
        n_generated++;
    endtask

    // Random read offset: half anywhere in the legal range, half near the
    // front so that most of them land inside short windows too.
    function automatic logic [tcws_pkg::IDX_W-1:0] rand_index();
        if ($urandom_range(0, 1) == 0)
            return tcws_pkg::IDX_W'($urandom_range(0, tcws_pkg::SIZE - 1));
        return tcws_pkg::IDX_W'($urandom_range(0, 127));
    endfunction

    //------------------------------------------------------------------
    // Clock and reset. Inputs go to known values at time zero.
    //------------------------------------------------------------------
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = tcws_pkg::CMD_APPEND;
        req_ch.char_in   = '0;
        req_ch.read_index = '0;
        res_ch.ready     = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    //------------------------------------------------------------------
    // Stimulus generator and end of test.
    //------------------------------------------------------------------
    initial
    begin
        int unsigned                 seg;
        int unsigned                 len;
        logic [tcws_pkg::CHAR_W-1:0] ch;
        bit                          flood_done;

        // Shadow reset: ring all newlines, ROWS-1 of them visible.
        for (int i = 0; i < tcws_pkg::SIZE; i++)
            ring[i] = tcws_pkg::NEWLINE;
        tail_pos = 0;
        win_len  = tcws_pkg::ROWS - 1;
        fill     = 0;
        nl_first = 0;
        nl_total = tcws_pkg::ROWS - 1;
        for (int i = 0; i < tcws_pkg::ROWS; i++)
            nl_list[i] = (i < tcws_pkg::ROWS - 1)
                         ? tcws_pkg::SIZE - (tcws_pkg::ROWS - 1) + i : 0;

        // Directed: reads of the reset window (first, last, one past, far
        // end, all low index bits), extreme bytes, and a run of newlines
        // that scrolls the initial blank lines out from the window start.
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd0, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'hFF, 11'd14, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd15, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'hFF, tcws_pkg::IDX_W'(tcws_pkg::SIZE - 1), 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd1023, 1'b0);
        push_req(tcws_pkg::CMD_APPEND, 8'h00, 11'd0, 1'b0);
        push_req(tcws_pkg::CMD_APPEND, 8'hFF, tcws_pkg::IDX_W'(tcws_pkg::SIZE - 1), 1'b0);
        push_req(tcws_pkg::CMD_APPEND, 8'd65, 11'd0, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd15, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd16, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd17, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd18, 1'b0);
        push_req(tcws_pkg::CMD_APPEND, tcws_pkg::NEWLINE, 11'd0, 1'b0);
        push_req(tcws_pkg::CMD_APPEND, tcws_pkg::NEWLINE, 11'd0, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd0, 1'b0);
        push_req(tcws_pkg::CMD_APPEND, tcws_pkg::NEWLINE, 11'd0, 1'b0);
        push_req(tcws_pkg::CMD_APPEND, 8'h7F, 11'd0, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd0, 1'b0);
        push_req(tcws_pkg::CMD_READ, 8'h00, 11'd1, 1'b0);

        // Random part. The first random request waits for a full drain.
        push_req(tcws_pkg::CMD_READ, 8'h00, rand_index(), 1'b1);
        flood_done = 1'b0;
        n_generated = 0;
        while (n_generated < RANDOM_REQS)
        begin
            seg = $urandom_range(0, 9);
            if (!flood_done && n_generated > 700)
                seg = 9;
            case (seg)
                5, 6:
                begin
                    len = $urandom_range(1, 8);
                    repeat (len)
                        push_req(tcws_pkg::CMD_READ, 8'($urandom), rand_index(), 1'b0);
                end
                7:
                begin
                    // noise: any command, any byte, any index
                    len = $urandom_range(1, 10);
                    repeat (len)
                        push_req(tcws_pkg::CMD_W'($urandom_range(0, 1)), 8'($urandom),
                                 tcws_pkg::IDX_W'($urandom_range(0, tcws_pkg::SIZE - 1)),
                                 1'b0);
                end
                8:
                begin
                    len = $urandom_range(1, 20);
                    repeat (len)
                        push_req(tcws_pkg::CMD_APPEND, tcws_pkg::NEWLINE, 11'($urandom),
                                 1'b0);
                end
                9:
                begin
                    if (!flood_done)
                    begin
                        // Long text with no newline: wraps every COLUMNS
                        // bytes, fills the ring and then evicts from it.
                        flood_done = 1'b1;
                        len = $urandom_range(tcws_pkg::SIZE + 10, tcws_pkg::SIZE + 110);
                        repeat (len)
                        begin
                            ch = 8'($urandom);
                            if (ch == tcws_pkg::NEWLINE)
                                ch = 8'd65;
                            push_req(tcws_pkg::CMD_APPEND, ch, 11'($urandom), 1'b0);
                            if ($urandom_range(0, 9) == 0)
                                push_req(tcws_pkg::CMD_READ, 8'($urandom), rand_index(),
                                         1'b0);
                        end
                    end
                end
                default:
                begin
                    // One line of text, often exactly full, mostly ended.
                    len = ($urandom_range(0, 7) == 0) ? tcws_pkg::COLUMNS
                                                      : $urandom_range(0, 100);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 19) == 0)
                            ch = 8'($urandom);
                        else
                            ch = 8'($urandom_range(32, 126));
                        push_req(tcws_pkg::CMD_APPEND, ch, 11'($urandom), 1'b0);
                        if ($urandom_range(0, 5) == 0)
                            push_req(tcws_pkg::CMD_READ, 8'($urandom), rand_index(), 1'b0);
                    end
                    if ($urandom_range(0, 99) < 85)
                        push_req(tcws_pkg::CMD_APPEND, tcws_pkg::NEWLINE, 11'($urandom),
                                 $urandom_range(0, 19) == 0);
                end
            endcase
        end

        // Wait for everything to go out and come back, then a short tail
        // to catch stray results.
        while (req_pending.size() > 0 || req_ch.valid || pending_views.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d line wraps, %0d appends with a full ring.",
                 n_accepted, n_wraps, n_full_ring);
        $display("Reads inside the window: %0d, past its end: %0d; mismatches: %0d.",
                 n_reads_in, n_reads_past, n_errors);
        if (n_errors == 0 && pending_views.size() == 0)
            $display("text_console_wrap_scroll_core: match");
        else
            $display("text_console_wrap_scroll_core: mismatch");
        $finish;
    end

    //------------------------------------------------------------------
    // Request driver: bursts of random length with random gaps, and an
    // occasional long burst with no gap at all.
    //------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        bit offer;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            burst_left = 8;
            gap_left   = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                pending_views.push_back(console_apply(cur));
                n_accepted++;
            end
            // A request still waiting for ready stays on the bus untouched.
            if (!(req_ch.valid && !req_ch.ready))
            begin
                offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (req_pending.size() > 0 &&
                         !(req_pending[0].drain && pending_views.size() > 0))
                begin
                    cur = req_pending.pop_front();
                    offer = 1'b1;
                    req_ch.cmd        <= cur.cmd;
                    req_ch.char_in    <= cur.ch;
                    req_ch.read_index <= cur.idx;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        gap_left   = $urandom_range(0, 12);
                        burst_left = ($urandom_range(0, 7) == 0) ? 200
                                                                 : $urandom_range(1, 24);
                    end
                end
                req_ch.valid <= offer;
            end
        end
    end

    //------------------------------------------------------------------
    // Result receiver: switches between always ready, random stalls and a
    // regular one-in-four stall; once it holds off so that the core backs up
    // and stops taking requests.
    //------------------------------------------------------------------
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        bit rdy;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (!hold_done && n_results >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 300;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(16, 160);
                end
                else
                    mode_left--;
                case (stall_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 2) != 0);
                    default: rdy = (mode_left % 4) != 0;
                endcase
            end
            res_ch.ready <= rdy;
        end
    end

    //------------------------------------------------------------------
    // Result monitor: each accepted result against the oldest prediction.
    //------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        view_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            n_results++;
            if (pending_views.size() == 0)
            begin
                $error("result with no request outstanding");
                n_errors++;
            end
            else
            begin
                want = pending_views.pop_front();
                check_field("read_char", want.read_char, res_ch.read_char);
                check_field("view_length", want.view_length, res_ch.view_length);
                check_field("line_fill", want.line_fill, res_ch.line_fill);
                check_field("view_start", want.view_start, res_ch.view_start);
            end
        end
    end

    //------------------------------------------------------------------
    // Watchdog on cycles where neither channel moves.
    //------------------------------------------------------------------
    int unsigned idle_cycles;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: nothing moved for %0d cycles, %0d results outstanding.",
                     IDLE_LIMIT, pending_views.size());
            $display("text_console_wrap_scroll_core: mismatch");
            $finish;
        end
    end

endmodule
